### src/lcd_rect_fill_bus_sequencer_macros.svh
// Assertion macros shared by the rectangle-fill bus sequencer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LCD_RECT_FILL_BUS_SEQUENCER_MACROS_SVH
`define LCD_RECT_FILL_BUS_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LRFBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrfbs assertion failed");

// next-cycle implication, checked outside reset
`define LRFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrfbs assertion failed");

`endif

### src/lrfbs_pkg.sv
// Package for the rectangle-fill bus sequencer: word types, codes, constants.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package lrfbs_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned WordW  = 16;
  localparam int unsigned StepW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CoordW-1:0] ScreenWidthRst  = 10'd800;
  localparam logic [CoordW-1:0] ScreenHeightRst = 10'd480;

  localparam logic [WordW-1:0] CMD_COLUMN_SET = 16'h002A;
  localparam logic [WordW-1:0] CMD_PAGE_SET   = 16'h002B;
  localparam logic [WordW-1:0] CMD_MEM_WRITE  = 16'h002C;
  localparam logic [WordW-1:0] BYTE_MASK      = 16'h00FF;

  // header sequence positions
  localparam logic [StepW-1:0] HS_COL_CMD   = 4'd0;
  localparam logic [StepW-1:0] HS_LEFT_HI   = 4'd1;
  localparam logic [StepW-1:0] HS_LEFT_LO   = 4'd2;
  localparam logic [StepW-1:0] HS_RIGHT_HI  = 4'd3;
  localparam logic [StepW-1:0] HS_RIGHT_LO  = 4'd4;
  localparam logic [StepW-1:0] HS_PAGE_CMD  = 4'd5;
  localparam logic [StepW-1:0] HS_TOP_HI    = 4'd6;
  localparam logic [StepW-1:0] HS_TOP_LO    = 4'd7;
  localparam logic [StepW-1:0] HS_BOTTOM_HI = 4'd8;
  localparam logic [StepW-1:0] HS_BOTTOM_LO = 4'd9;
  localparam logic [StepW-1:0] HS_MEM_CMD   = 4'd10;
  localparam logic [StepW-1:0] DATA_PHASE   = 4'd11;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_STEP  = 2'd1,
    FN_PIXEL = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BUSY  = 2'd2,
    ST_IDLE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [WordW-1:0] rect_x;
    logic [WordW-1:0] rect_y;
    logic [WordW-1:0] rect_w;
    logic [WordW-1:0] rect_h;
    logic [WordW-1:0] fill_colour;
    logic [WordW-1:0] pixel_in;
  } in_t;

  typedef struct packed {
    logic             bus_valid;
    logic             bus_is_command;
    logic [WordW-1:0] bus_word;
    logic             last;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
  } screen_t;

  typedef struct packed {
    logic             is_cmd;
    logic [WordW-1:0] word;
  } hdr_t;

  function automatic hdr_t header_word(input logic [StepW-1:0]  step,
                                       input logic [CoordW-1:0] left,
                                       input logic [CoordW-1:0] right,
                                       input logic [CoordW-1:0] top,
                                       input logic [CoordW-1:0] bottom);
    hdr_t h;
    h.is_cmd = 1'b0;
    case (step)
      HS_COL_CMD: begin
        h.is_cmd = 1'b1;
        h.word   = CMD_COLUMN_SET;
      end
      HS_LEFT_HI:   h.word = WordW'(left >> 8) & BYTE_MASK;
      HS_LEFT_LO:   h.word = WordW'(left) & BYTE_MASK;
      HS_RIGHT_HI:  h.word = WordW'(right >> 8) & BYTE_MASK;
      HS_RIGHT_LO:  h.word = WordW'(right) & BYTE_MASK;
      HS_PAGE_CMD: begin
        h.is_cmd = 1'b1;
        h.word   = CMD_PAGE_SET;
      end
      HS_TOP_HI:    h.word = WordW'(top >> 8) & BYTE_MASK;
      HS_TOP_LO:    h.word = WordW'(top) & BYTE_MASK;
      HS_BOTTOM_HI: h.word = WordW'(bottom >> 8) & BYTE_MASK;
      HS_BOTTOM_LO: h.word = WordW'(bottom) & BYTE_MASK;
      default: begin
        h.is_cmd = 1'b1;
        h.word   = CMD_MEM_WRITE;
      end
    endcase
    return h;
  endfunction

endpackage

### src/lrfbs_core.sv
// Input register, window/countdown state and per-word decode of the sequencer.
// Depends on lrfbs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lcd_rect_fill_bus_sequencer_macros.svh"

module lrfbs_core
  import lrfbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  screen_t screen_i,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_t     in_data_i,
  input  logic    buf_ready_i,
  output logic    push_o,
  output out_t    res_o
);

  logic              item_vld_q;
  in_t               item_q;
  logic              fire;

  logic [CoordW-1:0] win_left_q, win_left_d;
  logic [CoordW-1:0] win_right_q, win_right_d;
  logic [CoordW-1:0] win_top_q, win_top_d;
  logic [CoordW-1:0] win_bottom_q, win_bottom_d;
  logic [WordW-1:0]  held_colour_q, held_colour_d;
  logic [StepW-1:0]  header_step_q, header_step_d;
  logic [CoordW-1:0] cols_left_q, cols_left_d;
  logic [CoordW-1:0] rows_left_q, rows_left_d;
  logic              busy_q, busy_d;

  logic [WordW:0]    x_end, y_end;
  logic [CoordW-1:0] clip_right, clip_bottom;
  logic              off_screen;
  logic [CoordW-1:0] cols_dec, rows_dec;
  hdr_t              hdr;

  assign fire       = item_vld_q && buf_ready_i;
  assign in_stall_o = item_vld_q && !fire;
  assign push_o     = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  // start decode: reject and clip
  always_comb begin
    off_screen = (item_q.rect_x >= WordW'(screen_i.width))  ||
                 (item_q.rect_y >= WordW'(screen_i.height)) ||
                 (item_q.rect_w == '0) || (item_q.rect_h == '0);
    x_end = {1'b0, item_q.rect_x} + {1'b0, item_q.rect_w};
    y_end = {1'b0, item_q.rect_y} + {1'b0, item_q.rect_h};
    clip_right  = (x_end > (WordW+1)'(screen_i.width))  ? screen_i.width - 1'b1
                                                         : CoordW'(x_end - 1'b1);
    clip_bottom = (y_end > (WordW+1)'(screen_i.height)) ? screen_i.height - 1'b1
                                                         : CoordW'(y_end - 1'b1);
  end

  always_comb begin
    hdr = header_word(header_step_q, win_left_q, win_right_q, win_top_q, win_bottom_q);
    cols_dec = (cols_left_q != '0) ? cols_left_q - 1'b1 : '0;
    rows_dec = (rows_left_q != '0) ? rows_left_q - 1'b1 : '0;
  end

  always_comb begin
    res_o         = '0;
    win_left_d    = win_left_q;
    win_right_d   = win_right_q;
    win_top_d     = win_top_q;
    win_bottom_d  = win_bottom_q;
    held_colour_d = held_colour_q;
    header_step_d = header_step_q;
    cols_left_d   = cols_left_q;
    rows_left_d   = rows_left_q;
    busy_d        = busy_q;
    case (item_q.func)
      FN_START: begin
        if (busy_q) begin
          res_o.status = ST_BUSY;
        end else if (off_screen) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.status  = ST_OK;
          win_left_d    = item_q.rect_x[CoordW-1:0];
          win_right_d   = clip_right;
          win_top_d     = item_q.rect_y[CoordW-1:0];
          win_bottom_d  = clip_bottom;
          held_colour_d = item_q.fill_colour;
          header_step_d = HS_COL_CMD;
          cols_left_d   = clip_right - item_q.rect_x[CoordW-1:0] + 1'b1;
          rows_left_d   = clip_bottom - item_q.rect_y[CoordW-1:0] + 1'b1;
          busy_d        = 1'b1;
        end
      end
      FN_PIXEL: begin
        if (busy_q) begin
          res_o.status = ST_BUSY;
        end else begin
          res_o.status    = ST_OK;
          res_o.bus_valid = 1'b1;
          res_o.bus_word  = item_q.pixel_in;
        end
      end
      FN_STEP: begin
        if (!busy_q) begin
          res_o.status = ST_IDLE;
        end else if (header_step_q < DATA_PHASE) begin
          res_o.status         = ST_OK;
          res_o.bus_valid      = 1'b1;
          res_o.bus_is_command = hdr.is_cmd;
          res_o.bus_word       = hdr.word;
          header_step_d        = header_step_q + 1'b1;
        end else begin
          res_o.status    = ST_OK;
          res_o.bus_valid = 1'b1;
          res_o.bus_word  = held_colour_q;
          cols_left_d     = cols_dec;
          if (cols_dec == '0) begin
            rows_left_d = rows_dec;
            if (rows_dec == '0) begin
              res_o.last    = 1'b1;
              busy_d        = 1'b0;
              header_step_d = HS_COL_CMD;
            end else begin
              cols_left_d = win_right_q - win_left_q + 1'b1;
            end
          end
        end
      end
      default: begin
        res_o.status = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q    <= '0;
      win_right_q   <= '0;
      win_top_q     <= '0;
      win_bottom_q  <= '0;
      held_colour_q <= '0;
      header_step_q <= '0;
      cols_left_q   <= '0;
      rows_left_q   <= '0;
      busy_q        <= 1'b0;
    end else if (fire) begin
      win_left_q    <= win_left_d;
      win_right_q   <= win_right_d;
      win_top_q     <= win_top_d;
      win_bottom_q  <= win_bottom_d;
      held_colour_q <= held_colour_d;
      header_step_q <= header_step_d;
      cols_left_q   <= cols_left_d;
      rows_left_q   <= rows_left_d;
      busy_q        <= busy_d;
    end
  end

  `LRFBS_ASSERT_NOW(a_idle_step_zero, clk_i, rst_ni, !busy_q, header_step_q == HS_COL_CMD)
  `LRFBS_ASSERT_NOW(a_busy_counts_live, clk_i, rst_ni, busy_q,
                    (cols_left_q != '0) && (rows_left_q != '0))
  `LRFBS_ASSERT_NEXT(a_last_ends_fill, clk_i, rst_ni, fire && res_o.last, !busy_q)
  `LRFBS_ASSERT_NOW(a_step_in_range, clk_i, rst_ni, 1'b1, header_step_q <= DATA_PHASE)

endmodule

### src/lrfbs_outbuf.sv
// Two-entry result buffer: output register plus skid entry.
// Depends on lrfbs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lcd_rect_fill_bus_sequencer_macros.svh"

module lrfbs_outbuf
  import lrfbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t push_data_i,
  output logic ready_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic [1:0] cnt_q, cnt_d;
  out_t       head_q, skid_q;
  logic       pop;

  assign ready_o     = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = head_q;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q == 2'd2) begin
        head_q <= skid_q;
        if (push_i) begin
          skid_q <= push_data_i;
        end
      end else if (push_i) begin
        head_q <= push_data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        head_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

  `LRFBS_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= 2'd2)
  `LRFBS_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push_i, cnt_q != 2'd2)
  `LRFBS_ASSERT_NEXT(a_head_held, clk_i, rst_ni, out_valid_o && out_stall_i,
                     out_valid_o && (out_data_o == $past(head_q)))

endmodule

### src/lcd_rect_fill_bus_sequencer.sv
// Sequencer that turns start/step/pixel words into 8080-bus writes for a rectangle
// fill: column and page window headers, memory-write command, then the colour words.
// One word in gives one word out; a new word can be taken every cycle unless the input
// stalls. A taken word is held in the input register, and its result is then loaded
// into the result buffer and shown on the output from its head. The two-entry result
// buffer lets the input keep flowing while the output stalls, until both entries are
// full. Screen size registers are written through the cfg port (always ready) and apply
// to later start words.
`timescale 1ns / 1ps

module lcd_rect_fill_bus_sequencer
  import lrfbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_wdata_i
);

  screen_t screen_q;
  logic    buf_ready;
  logic    push;
  out_t    res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q.width  <= ScreenWidthRst;
      screen_q.height <= ScreenHeightRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_q.width  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: screen_q.height <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lrfbs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .screen_i    (screen_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .buf_ready_i (buf_ready),
    .push_o      (push),
    .res_o       (res)
  );

  lrfbs_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/tb_lcd_rect_fill_bus_sequencer.sv
// Self-checking testbench for lcd_rect_fill_bus_sequencer: directed and random
// start/step/pixel words under several screen sizes, idling and stall patterns.
// Depends on lrfbs_pkg and the RTL of the block; expected bus writes come from a predictor class.
`timescale 1ns / 1ps

module tb_lcd_rect_fill_bus_sequencer;
  import lrfbs_pkg::*;

  localparam logic [1:0]  FN_UNUSED   = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 200;

  class bus_write_predictor;
    logic [CoordW-1:0] screen_w = ScreenWidthRst;
    logic [CoordW-1:0] screen_h = ScreenHeightRst;
    logic [CoordW-1:0] win_left, win_right, win_top, win_bottom;
    logic [CoordW-1:0] cols_left, rows_left;
    logic [WordW-1:0]  held_colour;
    logic [StepW-1:0]  hdr_pos;
    bit                busy;
    out_t              expected_writes[$];
    int unsigned       mismatches;

    function new();
      win_left = '0; win_right = '0; win_top = '0; win_bottom = '0;
      cols_left = '0; rows_left = '0; held_colour = '0; hdr_pos = HS_COL_CMD;
      busy = 1'b0; mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
      if (idx == CFG_SCREEN_WIDTH) screen_w = val;
      else if (idx == CFG_SCREEN_HEIGHT) screen_h = val;
    endfunction

    function int outstanding();
      return expected_writes.size();
    endfunction

    function void accept_word(in_t w);
      out_t r;
      int unsigned x, y, fit_w, fit_h, sw, sh;
      r = '0;
      x = 32'(w.rect_x);
      y = 32'(w.rect_y);
      fit_w = 32'(w.rect_w);
      fit_h = 32'(w.rect_h);
      sw = 32'(screen_w);
      sh = 32'(screen_h);
      case (w.func)
        FN_START: begin
          if (busy) begin
            r.status = ST_BUSY;
          end else if (x >= sw || y >= sh || fit_w == 0 || fit_h == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (x + fit_w > sw) fit_w = sw - x;
            if (y + fit_h > sh) fit_h = sh - y;
            win_left    = CoordW'(x);
            win_right   = CoordW'(x + fit_w - 1);
            win_top     = CoordW'(y);
            win_bottom  = CoordW'(y + fit_h - 1);
            held_colour = w.fill_colour;
            hdr_pos     = HS_COL_CMD;
            cols_left   = CoordW'(fit_w);
            rows_left   = CoordW'(fit_h);
            busy        = 1'b1;
            r.status    = ST_OK;
          end
        end
        FN_PIXEL: begin
          if (busy) begin
            r.status = ST_BUSY;
          end else begin
            r.bus_valid = 1'b1;
            r.bus_word  = w.pixel_in;
            r.status    = ST_OK;
          end
        end
        FN_STEP: begin
          if (!busy) begin
            r.status = ST_IDLE;
          end else if (hdr_pos != DATA_PHASE) begin
            r.bus_valid = 1'b1;
            r.status    = ST_OK;
            case (hdr_pos)
              HS_COL_CMD: begin
                r.bus_is_command = 1'b1;
                r.bus_word = CMD_COLUMN_SET;
              end
              HS_LEFT_HI:   r.bus_word = WordW'(win_left >> 8);
              HS_LEFT_LO:   r.bus_word = WordW'(win_left[7:0]);
              HS_RIGHT_HI:  r.bus_word = WordW'(win_right >> 8);
              HS_RIGHT_LO:  r.bus_word = WordW'(win_right[7:0]);
              HS_PAGE_CMD: begin
                r.bus_is_command = 1'b1;
                r.bus_word = CMD_PAGE_SET;
              end
              HS_TOP_HI:    r.bus_word = WordW'(win_top >> 8);
              HS_TOP_LO:    r.bus_word = WordW'(win_top[7:0]);
              HS_BOTTOM_HI: r.bus_word = WordW'(win_bottom >> 8);
              HS_BOTTOM_LO: r.bus_word = WordW'(win_bottom[7:0]);
              default: begin
                r.bus_is_command = 1'b1;
                r.bus_word = CMD_MEM_WRITE;
              end
            endcase
            hdr_pos = hdr_pos + 1'b1;
          end else begin
            r.bus_valid = 1'b1;
            r.bus_word  = held_colour;
            r.status    = ST_OK;
            if (cols_left != 0) cols_left = cols_left - 1'b1;
            if (cols_left == 0) begin
              if (rows_left != 0) rows_left = rows_left - 1'b1;
              if (rows_left == 0) begin
                r.last  = 1'b1;
                busy    = 1'b0;
                hdr_pos = HS_COL_CMD;
              end else begin
                cols_left = win_right - win_left + 1'b1;
              end
            end
          end
        end
        default: r.status = ST_IDLE;
      endcase
      expected_writes.push_back(r);
    endfunction

    function void compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_write(out_t got);
      out_t want;
      if (expected_writes.size() == 0) begin
        $display("%0t: bus word with nothing expected, expected none got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_writes.pop_front();
      compare_field("bus_valid", WordW'(want.bus_valid), WordW'(got.bus_valid));
      compare_field("bus_is_command", WordW'(want.bus_is_command), WordW'(got.bus_is_command));
      compare_field("bus_word", want.bus_word, got.bus_word);
      compare_field("last", WordW'(want.last), WordW'(got.last));
      compare_field("status", WordW'(want.status), WordW'(got.status));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoordW-1:0]  cfg_wdata = '0;

  bus_write_predictor bus_writes = new();
  int unsigned        sender_idle_pct = 0;
  int unsigned        stall_pct = 0;
  logic               hold_trigger = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        cycle_count = 0;

  lcd_rect_fill_bus_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_trigger && hold_left == 0) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    out_stall <= hold_trigger || hold_left != 0 || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) bus_writes.accept_word(in_word);
      if (out_valid && !out_stall) bus_writes.check_write(out_word);
    end
  end

  function automatic in_t make_word(logic [1:0] fn, logic [WordW-1:0] x, logic [WordW-1:0] y,
                                    logic [WordW-1:0] w, logic [WordW-1:0] h,
                                    logic [WordW-1:0] colour, logic [WordW-1:0] pixel);
    in_t s;
    s.func = fn;
    s.rect_x = x;
    s.rect_y = y;
    s.rect_w = w;
    s.rect_h = h;
    s.fill_colour = colour;
    s.pixel_in = pixel;
    return s;
  endfunction

  function automatic in_t random_word(logic [1:0] fn);
    return make_word(fn, WordW'($urandom), WordW'($urandom), WordW'($urandom),
                     WordW'($urandom), WordW'($urandom), WordW'($urandom));
  endfunction

  function automatic in_t bad_start(int unsigned sw, int unsigned sh);
    in_t s;
    s = random_word(FN_START);
    case ($urandom_range(3))
      0: s.rect_x = WordW'($urandom_range(65535, sw));
      1: s.rect_y = WordW'($urandom_range(65535, sh));
      2: s.rect_w = '0;
      default: s.rect_h = '0;
    endcase
    return s;
  endfunction

  // header words plus clipped area, for a start that the block will take
  function automatic int fill_words(in_t s);
    int unsigned cw, ch, x, y, sw, sh;
    x  = 32'(s.rect_x);
    y  = 32'(s.rect_y);
    cw = 32'(s.rect_w);
    ch = 32'(s.rect_h);
    sw = 32'(bus_writes.screen_w);
    sh = 32'(bus_writes.screen_h);
    if (x + cw > sw) cw = sw - x;
    if (y + ch > sh) ch = sh - y;
    return int'(DATA_PHASE) + int'(cw * ch);
  endfunction

  task automatic send_word(in_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_fill(in_t start, int unsigned noise_pct, output int words);
    int n;
    n = fill_words(start);
    send_word(start);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: send_word(random_word(FN_START));
          1: send_word(random_word(FN_PIXEL));
          default: send_word(random_word(FN_UNUSED));
        endcase
      end
      send_word(random_word(FN_STEP));
    end
    words = n + 1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bus_writes.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    bus_writes.set_reg(idx, val);
  endtask

  task automatic set_screen(logic [CoordW-1:0] w, logic [CoordW-1:0] h);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_words();
    int words;
    send_word(make_word(FN_STEP, '0, '0, '0, '0, '0, '0));
    send_word(make_word(FN_UNUSED, '1, '1, '1, '1, '1, '1));
    send_word(make_word(FN_PIXEL, '0, '0, '0, '0, '0, 16'h0000));
    send_word(make_word(FN_PIXEL, '1, '1, '1, '1, '1, 16'hFFFF));
    send_word(make_word(FN_START, 16'd800, 16'd0, 16'd1, 16'd1, 16'h1234, '0));
    send_word(make_word(FN_START, 16'd0, 16'd480, 16'd1, 16'd1, 16'h1234, '0));
    send_word(make_word(FN_START, 16'd0, 16'd0, 16'd0, 16'd5, 16'h1234, '0));
    send_word(make_word(FN_START, 16'd0, 16'd0, 16'd5, 16'd0, 16'h1234, '0));
    send_word(make_word(FN_START, '1, '1, '1, '1, '1, '1));
    // one pixel in the far corner, clipped from maximum size; busy probes before its first header word
    send_word(make_word(FN_START, 16'd799, 16'd479, '1, '1, 16'hFFFF, '0));
    send_word(make_word(FN_START, '0, '0, 16'd1, 16'd1, '0, '0));
    send_word(make_word(FN_PIXEL, '0, '0, '0, '0, '0, 16'hA5A5));
    for (int i = 0; i < int'(DATA_PHASE) + 1; i++) send_word(random_word(FN_STEP));
    send_word(random_word(FN_STEP));
    run_fill(make_word(FN_START, 16'd0, 16'd0, 16'd8, 16'd1, 16'h07E0, '0), 0, words);
    run_fill(make_word(FN_START, 16'd3, 16'd2, 16'd1, 16'd4, 16'hF800, '0), 0, words);
    // long receiver hold-off while the sender keeps offering steps
    hold_trigger <= 1'b1;
    @(posedge clk);
    hold_trigger <= 1'b0;
    run_fill(make_word(FN_START, 16'd100, 16'd300, 16'd6, 16'd5, 16'h001F, '0), 0, words);
  endtask

  task automatic run_random(int budget);
    int sent, words;
    int unsigned sw, sh, room;
    in_t s;
    sent = 0;
    while (sent < budget) begin
      sw = 32'(bus_writes.screen_w);
      sh = 32'(bus_writes.screen_h);
      if (sw == 0 || sh == 0 || $urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0: begin
            send_word(random_word(FN_PIXEL));
            sent++;
          end
          1: begin
            send_word(bad_start(sw, sh));
            sent++;
          end
          2: send_word(random_word(FN_STEP));
          default: send_word(random_word(FN_UNUSED));
        endcase
      end else begin
        s = random_word(FN_START);
        if ($urandom_range(9) == 0) begin
          room = (sw > 4) ? 3 : sw - 1;
          s.rect_x = WordW'(sw - 1 - $urandom_range(room));
          s.rect_w = WordW'($urandom_range(65535, 1));
        end else begin
          s.rect_x = WordW'($urandom_range(sw - 1));
          s.rect_w = WordW'($urandom_range(6, 1));
        end
        if ($urandom_range(9) == 0) begin
          room = (sh > 4) ? 3 : sh - 1;
          s.rect_y = WordW'(sh - 1 - $urandom_range(room));
          s.rect_h = WordW'($urandom_range(65535, 1));
        end else begin
          s.rect_y = WordW'($urandom_range(sh - 1));
          s.rect_h = WordW'($urandom_range(6, 1));
        end
        run_fill(s, 8, words);
        sent += words;
        if ($urandom_range(3) == 0) send_word(random_word(FN_STEP));
      end
    end
  endtask

  initial begin
    int words;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
        1: begin sender_idle_pct = 86; stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  stall_pct <= 86; end
        default: begin sender_idle_pct = 26; stall_pct <= 26; end
      endcase
      case (p)
        0: directed_words();
        1: begin
          set_screen(10'd1023, 10'd1023);
          run_fill(make_word(FN_START, 16'd1020, 16'd1022, 16'd100, 16'd5, 16'hBEEF, '0),
                   0, words);
        end
        2: set_screen(10'd1, 10'd1);
        3: begin
          write_reg(CFG_UNUSED, CoordW'($urandom));
          set_screen(10'd0, 10'd0);
        end
        4: begin
          set_screen(10'd20, 10'd12);
          run_fill(make_word(FN_START, '0, '0, 16'd20, 16'd12, 16'h8410, '0), 0, words);
          run_fill(make_word(FN_START, '0, '0, '1, '1, 16'h7BEF, '0), 0, words);
        end
        5: set_screen(CoordW'($urandom_range(1023, 1)), CoordW'($urandom_range(1023, 1)));
        6: set_screen(10'd37, 10'd5);
        default: set_screen(10'd800, 10'd480);
      endcase
      run_random((p == 3) ? 40 : (p == 4) ? 100 : 160);
    end
    drain();
    repeat (4) @(posedge clk);
    if (bus_writes.mismatches == 0 && bus_writes.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/lrfbs_pkg.sv
src/lrfbs_core.sv
src/lrfbs_outbuf.sv
src/lcd_rect_fill_bus_sequencer.sv
test/tb_lcd_rect_fill_bus_sequencer.sv
